// ===== rtl/core/iirc_pkg.sv =====
// shared constants and types for the clamped iir filter
package iirc_pkg;

  localparam int unsigned Order    = 2;
  localparam int unsigned NumTaps  = Order + 1;
  localparam int unsigned DenTaps  = Order;
  localparam int unsigned NumTerms = NumTaps + DenTaps;
  localparam int unsigned TermW    = $clog2(NumTerms + 1);

  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned AccW  = ProdW + 3;
  localparam int unsigned FracW = 28;
  localparam int unsigned YW    = AccW - FracW;

  localparam int unsigned IdxW  = 3;
  localparam int unsigned AddrW = IdxW + 2;

  localparam logic [IdxW-1:0] RegCoefB0    = 3'd0;
  localparam logic [IdxW-1:0] RegCoefB1    = 3'd1;
  localparam logic [IdxW-1:0] RegCoefB2    = 3'd2;
  localparam logic [IdxW-1:0] RegCoefA1    = 3'd3;
  localparam logic [IdxW-1:0] RegCoefA2    = 3'd4;
  localparam logic [IdxW-1:0] RegLimitLow  = 3'd5;
  localparam logic [IdxW-1:0] RegLimitHigh = 3'd6;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    word_t [2:0] coef_b;
    word_t [1:0] coef_a;
    word_t       limit_low;
    word_t       limit_high;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             mul_en;
    logic             acc_en;
    logic [TermW-1:0] term;
    logic             finish;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMac  = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

// ===== rtl/core/iir_filter_with_output_clamp_unit.sv =====
// top level of the direct form one iir filter with output clamp
//
// sample_in_i enters on the in_valid_i / in_ready_o handshake, one signed
// q16.16 sample per item. each item yields one result on out_valid_o /
// out_ready_i: filtered_out_o (q16.16) and clamped_o.
// coefficients (q4.28) and limits are written over the apb port, one
// register every 4 bytes. the user must write them only while the filter
// is idle; the block itself does not enforce this. taking an item loads
// the histories, the five products then go through one shared 32x32
// multiplier and the accumulator, and a last step rounds, clamps and
// loads the output register. in_ready_o is high only while no item is
// being worked on, so one item is in flight at a time.
// the result register lets the next item be taken while a result waits;
// a stalled receiver holds the finished item back and input stops.
// reset clears the histories, sets b0 to 1.0, the other taps to zero and
// the limits to full range, and leaves no result pending.
module iir_filter_with_output_clamp_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [iirc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic signed [31:0]         sample_in_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic signed [31:0]         filtered_out_o,
  output logic                       clamped_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i
);
  import iirc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  iirc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iirc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  iirc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sample_in_i    (sample_in_i),
    .filtered_out_o (filtered_out_o),
    .clamped_o      (clamped_o)
  );

endmodule

// ===== rtl/core/iirc_regs.sv =====
// apb configuration registers for the clamped iir filter
module iirc_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [iirc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output iirc_pkg::cfg_t            cfg_o
);
  import iirc_pkg::*;

  cfg_t            cfg_q;
  logic [IdxW-1:0] idx;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_b[0]  <= word_t'(32'h1000_0000);
      cfg_q.coef_b[1]  <= '0;
      cfg_q.coef_b[2]  <= '0;
      cfg_q.coef_a[0]  <= '0;
      cfg_q.coef_a[1]  <= '0;
      cfg_q.limit_low  <= word_t'(32'h8000_0000);
      cfg_q.limit_high <= word_t'(32'h7fff_ffff);
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegCoefB0:    cfg_q.coef_b[0]  <= pwdata;
        RegCoefB1:    cfg_q.coef_b[1]  <= pwdata;
        RegCoefB2:    cfg_q.coef_b[2]  <= pwdata;
        RegCoefA1:    cfg_q.coef_a[0]  <= pwdata;
        RegCoefA2:    cfg_q.coef_a[1]  <= pwdata;
        RegLimitLow:  cfg_q.limit_low  <= pwdata;
        RegLimitHigh: cfg_q.limit_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegCoefB0:    prdata = cfg_q.coef_b[0];
      RegCoefB1:    prdata = cfg_q.coef_b[1];
      RegCoefB2:    prdata = cfg_q.coef_b[2];
      RegCoefA1:    prdata = cfg_q.coef_a[0];
      RegCoefA2:    prdata = cfg_q.coef_a[1];
      RegLimitLow:  prdata = cfg_q.limit_low;
      RegLimitHigh: prdata = cfg_q.limit_high;
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/iirc_ctrl.sv =====
// sequencing state machine for the clamped iir filter
module iirc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iirc_pkg::cmd_t cmd_o
);
  import iirc_pkg::*;

  state_e           state_q, state_d;
  logic [TermW-1:0] term_q, term_d;
  logic             out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    term_d        = term_q;
    cmd_o         = '0;
    cmd_o.term    = term_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          term_d      = '0;
          state_d     = StMac;
        end
      end
      StMac: begin
        cmd_o.mul_en = (term_q < TermW'(NumTerms));
        cmd_o.acc_en = (term_q != '0);
        term_d       = term_q + TermW'(1);
        if (term_q == TermW'(NumTerms)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      term_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/iirc_dp.sv =====
// history registers, shared multiplier, accumulator and clamp
module iirc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iirc_pkg::cfg_t        cfg_i,
  input  iirc_pkg::cmd_t        cmd_i,
  input  logic signed [31:0]    sample_in_i,
  output logic signed [31:0]    filtered_out_o,
  output logic                  clamped_o
);
  import iirc_pkg::*;

  word_t                   x_hist_q [NumTaps];
  word_t                   y_hist_q [DenTaps];
  word_t                   last_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    neg_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  prod_ext;
  word_t                   op_c, op_x;
  logic                    op_neg;
  logic signed [YW-1:0]    y_wide;
  word_t                   y_sat, y_fin;
  logic                    cut;
  word_t                   out_q;
  logic                    clamped_q;

  localparam logic signed [YW-1:0] WordMax = YW'($signed(32'h7fff_ffff));
  localparam logic signed [YW-1:0] WordMin = YW'($signed(32'h8000_0000));

  always_comb begin
    op_c   = '0;
    op_x   = '0;
    op_neg = 1'b0;
    for (int i = 0; i < NumTaps; i++) begin
      if (cmd_i.term == TermW'(i)) begin
        op_c = cfg_i.coef_b[i];
        op_x = x_hist_q[i];
      end
    end
    for (int i = 0; i < DenTaps; i++) begin
      if (cmd_i.term == TermW'(NumTaps + i)) begin
        op_c   = cfg_i.coef_a[i];
        op_x   = y_hist_q[i];
        op_neg = 1'b1;
      end
    end
  end

  assign prod_ext = AccW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= AccW'(1) << (FracW - 1);
    end else if (cmd_i.acc_en) begin
      acc_q <= neg_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(op_c) * ProdW'(op_x);
      neg_q  <= op_neg;
    end
  end

  always_comb begin
    y_wide = acc_q[AccW-1:FracW];
    cut    = 1'b0;
    if (y_wide > WordMax) begin
      y_sat = word_t'(32'h7fff_ffff);
      cut   = 1'b1;
    end else if (y_wide < WordMin) begin
      y_sat = word_t'(32'h8000_0000);
      cut   = 1'b1;
    end else begin
      y_sat = y_wide[DataW-1:0];
    end
    y_fin = y_sat;
    if (y_fin > cfg_i.limit_high) begin
      y_fin = cfg_i.limit_high;
      cut   = 1'b1;
    end
    if (y_fin < cfg_i.limit_low) begin
      y_fin = cfg_i.limit_low;
      cut   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTaps; i++) begin
        x_hist_q[i] <= '0;
      end
      for (int i = 0; i < DenTaps; i++) begin
        y_hist_q[i] <= '0;
      end
      last_q <= '0;
    end else begin
      if (cmd_i.start) begin
        for (int i = NumTaps - 1; i > 0; i--) begin
          x_hist_q[i] <= x_hist_q[i-1];
        end
        x_hist_q[0] <= sample_in_i;
        for (int i = DenTaps - 1; i > 0; i--) begin
          y_hist_q[i] <= y_hist_q[i-1];
        end
        y_hist_q[0] <= last_q;
      end
      if (cmd_i.finish) begin
        last_q <= y_fin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q     <= y_fin;
      clamped_q <= cut;
    end
  end

  assign filtered_out_o = out_q;
  assign clamped_o      = clamped_q;

endmodule

// ===== rtl/core/iirc_checker.sv =====
// port checker for the clamped iir filter and its bind
module iirc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] filtered_out_o,
  input logic        clamped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(filtered_out_o) && $stable(clamped_o))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after an item");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result loaded without returning to idle");

endmodule

bind iir_filter_with_output_clamp_unit iirc_checker u_iirc_checker (.*);

// ===== tb/tb_iir_filter_with_output_clamp_unit.sv =====
// self-checking testbench for the clamped direct form one iir filter
`timescale 1ns / 1ps

module tb_iir_filter_with_output_clamp_unit;
  import iirc_pkg::*;

  localparam logic [IdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned RandPhases = 7;
  localparam int unsigned PhaseItems = 155;

  typedef struct {
    word_t value;
    logic  clamped;
  } filter_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic signed [31:0] sample_in_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] filtered_out_o;
  logic               clamped_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;

  iir_filter_with_output_clamp_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_in_i    (sample_in_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .filtered_out_o (filtered_out_o),
    .clamped_o      (clamped_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // filter mirror
  cfg_t           cfg_mirror;
  word_t          x_hist [3];
  word_t          y_hist [2];
  word_t          last_y;

  word_t          sample_queue [$];
  filter_result_t pending_outputs [$];
  filter_result_t head_result;

  logic           quiet_mode = 1'b0;
  logic           sender_hold = 1'b0;
  int             tx_gap;
  int             rx_stall;
  int             n_errors = 0;
  int             n_samples = 0;
  int             n_settings = 0;
  int             n_clamped = 0;

  function automatic longint mul_q(input word_t a, input word_t b);
    longint pa;
    longint pb;
    pa = a;
    pb = b;
    return pa * pb;
  endfunction

  function automatic void predict_filter_output(input word_t x);
    logic signed [79:0] acc;
    logic signed [79:0] rounded;
    word_t              y;
    logic               cut;
    filter_result_t     res;
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[1] = y_hist[0];
    y_hist[0] = last_y;
    acc = '0;
    acc = acc + mul_q(cfg_mirror.coef_b[0], x_hist[0]);
    acc = acc + mul_q(cfg_mirror.coef_b[1], x_hist[1]);
    acc = acc - mul_q(cfg_mirror.coef_a[0], y_hist[0]);
    if (Order > 1) begin
      acc = acc + mul_q(cfg_mirror.coef_b[2], x_hist[2]);
      acc = acc - mul_q(cfg_mirror.coef_a[1], y_hist[1]);
    end
    acc = acc + 80'sd134217728;
    rounded = acc >>> FracW;
    cut = 1'b0;
    if (rounded > 80'sd2147483647) begin
      y = 32'sh7FFF_FFFF;
      cut = 1'b1;
    end else if (rounded < -80'sd2147483648) begin
      y = 32'sh8000_0000;
      cut = 1'b1;
    end else begin
      y = rounded[31:0];
    end
    if (y > cfg_mirror.limit_high) begin
      y = cfg_mirror.limit_high;
      cut = 1'b1;
    end
    if (y < cfg_mirror.limit_low) begin
      y = cfg_mirror.limit_low;
      cut = 1'b1;
    end
    last_y = y;
    res.value = y;
    res.clamped = cut;
    pending_outputs.insert(pending_outputs.size(), res);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'sh0000_0001;
      default: return 32'shFFFF_FFFF;
    endcase
  endfunction

  function automatic word_t rand_coef(input int style);
    case (style)
      0: return word_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      1: return word_t'($urandom);
      default: return pick_extreme();
    endcase
  endfunction

  function automatic word_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return word_t'($urandom);
    if (r < 85) return word_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    return pick_extreme();
  endfunction

  task automatic apb_write(input logic [IdxW-1:0] idx, input word_t val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegCoefB0:    cfg_mirror.coef_b[0] = val;
      RegCoefB1:    cfg_mirror.coef_b[1] = val;
      RegCoefB2:    cfg_mirror.coef_b[2] = val;
      RegCoefA1:    cfg_mirror.coef_a[0] = val;
      RegCoefA2:    cfg_mirror.coef_a[1] = val;
      RegLimitLow:  cfg_mirror.limit_low = val;
      RegLimitHigh: cfg_mirror.limit_high = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || pending_outputs.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_all(input word_t b0, input word_t b1, input word_t b2,
                           input word_t a1, input word_t a2,
                           input word_t lo, input word_t hi);
    apb_write(RegCoefB0, b0);
    apb_write(RegCoefB1, b1);
    apb_write(RegCoefB2, b2);
    apb_write(RegCoefA1, a1);
    apb_write(RegCoefA2, a2);
    apb_write(RegLimitLow, lo);
    apb_write(RegLimitHigh, hi);
    n_settings++;
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_filter_output(sample_in_i);
        n_samples++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0 && !sender_hold) begin
          sample_in_i <= sample_queue.pop_front();
          in_valid_i  <= 1'b1;
          tx_gap = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (clamped_o) n_clamped++;
        if (pending_outputs.size() == 0) begin
          $error("unexpected item: filtered_out %0d clamped %0b", filtered_out_o, clamped_o);
          n_errors++;
        end else begin
          head_result = pending_outputs.pop_front();
          if (filtered_out_o !== head_result.value) begin
            $error("filtered_out expected %0d actual %0d", head_result.value, filtered_out_o);
            n_errors++;
          end
          if (clamped_o !== head_result.clamped) begin
            $error("clamped expected %0b actual %0b", head_result.clamped, clamped_o);
            n_errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_stall = idle_len();
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_outputs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int    coef_style [RandPhases];
    int    limit_style [RandPhases];
    word_t lo;
    word_t hi;
    word_t t;
    int    st;
    coef_style  = '{0, 0, 1, 0, 2, 1, 0};
    limit_style = '{0, 1, 0, 3, 1, 2, 1};
    cfg_mirror.coef_b[0]  = 32'sh1000_0000;
    cfg_mirror.coef_b[1]  = '0;
    cfg_mirror.coef_b[2]  = '0;
    cfg_mirror.coef_a[0]  = '0;
    cfg_mirror.coef_a[1]  = '0;
    cfg_mirror.limit_low  = 32'sh8000_0000;
    cfg_mirror.limit_high = 32'sh7FFF_FFFF;
    x_hist = '{default: '0};
    y_hist = '{default: '0};
    last_y = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity at reset settings
    sample_queue = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, 32'shFFFF_FFFF,
                     32'sh0001_0000};
    settle();

    // half lsb rounding toward plus infinity
    write_all(32'sh0800_0000, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    sample_queue = '{32'sh1, -32'sh1, 32'sh3, -32'sh3};
    settle();

    // word overflow both ways
    write_all(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    sample_queue = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    settle();

    // limits
    write_all(32'sh1000_0000, 0, 0, 0, 0, -32'sh0001_0000, 32'sh0001_0000);
    sample_queue = '{32'sh0002_0000, -32'sh0002_0000, 32'sh0000_8000};
    settle();

    // crossed limits and an unmapped register
    apb_write(RegUnused, 32'sh5A5A_5A5A);
    apb_write(RegLimitLow, 32'sh0001_0000);
    apb_write(RegLimitHigh, -32'sh0001_0000);
    sample_queue = '{32'sh0, 32'sh5};
    settle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      quiet_mode = (ph == 2);
      st = coef_style[ph];
      case (limit_style[ph])
        0: begin
          lo = 32'sh8000_0000;
          hi = 32'sh7FFF_FFFF;
        end
        1, 2: begin
          lo = word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
          hi = word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
          if ((lo > hi) != (limit_style[ph] == 2)) begin
            t = lo;
            lo = hi;
            hi = t;
          end
        end
        default: begin
          lo = pick_extreme();
          hi = pick_extreme();
        end
      endcase
      write_all(rand_coef(st) + 32'sh0800_0000, rand_coef(st), rand_coef(st),
                rand_coef(st), rand_coef(st), lo, hi);
      for (int i = 0; i < PhaseItems; i++) sample_queue.insert(sample_queue.size(), rand_sample());
      if (ph == 4) begin
        do @(negedge clk_i); while (sample_queue.size() > PhaseItems / 2);
        sender_hold = 1'b1;
        do @(negedge clk_i); while (in_valid_i || pending_outputs.size() != 0);
        repeat (5) @(negedge clk_i);
        sender_hold = 1'b0;
      end
      settle();
    end

    $display("covered %0d samples under %0d filter settings, %0d outputs clamped",
             n_samples, n_settings, n_clamped);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
